[rtl/kci_pkg.sv]
package kci_pkg;

	localparam logic FUNC_WRITE = 1'b0;
	localparam logic FUNC_EVAL  = 1'b1;

	localparam logic REG_POINT_COUNT  = 1'b0;
	localparam logic REG_OUTPUT_RANGE = 1'b1;

	localparam int ROUND_ADD  = 327680000;
	localparam int SAT_LIMIT  = 655360000;
	localparam logic [15:0] OUT_MAX = 16'hFFFF;

	// ceil(2^44 / 10000), exact floor division for dividends below 2^30
	localparam logic [30:0] RECIP_FULL_SCALE = 31'd1759218605;
	localparam int          RECIP_SHIFT      = 44;

	typedef struct packed {
		logic        func;
		logic [4:0]  point_index;
		logic [19:0] point_time_ms;
		logic [13:0] point_value;
		logic        point_smooth;
		logic [19:0] eval_time_ms;
	} in_word_t;

	typedef struct packed {
		logic [15:0] out_value;
		logic        in_segment;
		logic        table_empty;
	} out_word_t;

	typedef enum logic [11:0] {
		ST_IDLE  = 12'b0000_0000_0001,
		ST_SCAN  = 12'b0000_0000_0010,
		ST_TDIV  = 12'b0000_0000_0100,
		ST_SQ    = 12'b0000_0000_1000,
		ST_CU    = 12'b0000_0001_0000,
		ST_POLY  = 12'b0000_0010_0000,
		ST_BLEND = 12'b0000_0100_0000,
		ST_SUM   = 12'b0000_1000_0000,
		ST_SCALE = 12'b0001_0000_0000,
		ST_RND   = 12'b0010_0000_0000,
		ST_OCHK  = 12'b0100_0000_0000,
		ST_ODIV  = 12'b1000_0000_0000
	} state_t;

endpackage

[rtl/kci_ram.sv]
module kci_ram #(
	parameter int WIDTH = 35,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[rtl/kci_div.sv]
module kci_div #(
	parameter int DW = 37,
	parameter int QW = 17
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          go,
	input  logic [DW-1:0] num,
	input  logic [DW-1:0] den,
	output logic          done,
	output logic [QW-1:0] quot
);

	localparam int BW = $clog2(QW);

	logic [DW-1:0] rem_q;
	logic [DW-1:0] den_q;
	logic [QW-1:0] quot_q;
	logic [BW-1:0] bit_q;
	logic          run_q;
	logic          done_q;
	logic [DW-1:0] trial;
	logic          ge;

	assign trial = den_q << bit_q;
	assign ge    = rem_q >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				run_q <= 1'b1;
			end else if (run_q && bit_q == '0) begin
				run_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			rem_q  <= num;
			den_q  <= den;
			bit_q  <= BW'(QW - 1);
			quot_q <= '0;
		end else if (run_q) begin
			quot_q <= {quot_q[QW-2:0], ge};
			if (ge) begin
				rem_q <= rem_q - trial;
			end
			bit_q <= bit_q - 1'b1;
		end
	end

	assign done = done_q;
	assign quot = quot_q;

endmodule

[rtl/keyframe_curve_interpolator_top.sv]
// channel  | signals                         | word
// command  | start, busy                     | cmd (kci_pkg::in_word_t)
// result   | done                            | result (kci_pkg::out_word_t)
// config   | cfg_we, cfg_index, cfg_data     | register write
// a keyframe write gives no word
// an evaluation scans the table one entry a cycle through the ram read port,
// then, for a segment of nonzero length, a serial divide for t and, if a key is
// smooth, three smoothstep steps; scale, round and reciprocal steps follow
// reset clears control state only; keyframes are undefined until written
// the receiver cannot stall: done is high for one cycle per evaluation
module keyframe_curve_interpolator_top #(
	parameter int MAX_POINTS = 32,
	parameter int TIME_BITS  = 20
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  kci_pkg::in_word_t   cmd,
	output logic                done,
	output kci_pkg::out_word_t  result,
	input  logic                cfg_we,
	input  logic                cfg_index,
	input  logic [15:0]         cfg_data
);

	localparam int AW = $clog2(MAX_POINTS);
	localparam int NW = ($clog2(MAX_POINTS + 1) > 6) ? $clog2(MAX_POINTS + 1) : 6;
	localparam int EW = TIME_BITS + 15;
	localparam int CW = (TIME_BITS > 20) ? TIME_BITS : 20;
	localparam int DW = (TIME_BITS + 17 > 31) ? TIME_BITS + 17 : 31;

	kci_pkg::state_t state_q;
	logic [5:0]           count_q;
	logic [15:0]          range_q;
	logic [NW-1:0]        cnt_q;
	logic [NW-1:0]        ptr_q;
	logic                 have_prev_q;
	logic [TIME_BITS-1:0] prev_t_q;
	logic [13:0]          prev_v_q;
	logic                 prev_sm_q;
	logic [CW-1:0]        e_q;
	logic [DW-1:0]        div_num_q;
	logic [DW-1:0]        div_den_q;
	logic                 div_go_q;
	logic [13:0]          v0_q;
	logic [13:0]          v1_q;
	logic                 smooth_q;
	logic [16:0]          t_q;
	logic [33:0]          sq_q;
	logic [49:0]          cu_q;
	logic [16:0]          s_q;
	logic signed [32:0]   prod_q;
	logic [29:0]          v_q;
	logic [45:0]          x_q;
	logic [30:0]          y_q;
	logic [60:0]          quo_q;
	logic                 seg_q;
	logic                 done_q;
	kci_pkg::out_word_t   result_q;

	logic                 accept;
	logic                 ram_we;
	logic [AW-1:0]        ram_raddr;
	logic [EW-1:0]        ram_rdata;
	logic [TIME_BITS-1:0] cur_t;
	logic [13:0]          cur_v;
	logic                 cur_sm;
	logic [NW-1:0]        count_ext;
	logic [NW-1:0]        cnt_eff;
	logic                 hit;
	logic [TIME_BITS-1:0] seg_len;
	logic [TIME_BITS-1:0] seg_off;
	logic                 div_done;
	logic [16:0]          div_quot;
	logic [50:0]          poly;
	logic signed [14:0]   dv;
	logic signed [17:0]   sx;
	logic signed [32:0]   vsum;
	logic [46:0]          xr;
	logic [15:0]          range_eff;

	assign accept    = start && !busy;
	assign busy      = state_q != kci_pkg::ST_IDLE;
	assign ram_we    = accept && cmd.func == kci_pkg::FUNC_WRITE
		&& 32'(cmd.point_index) < MAX_POINTS;
	assign ram_raddr = (state_q == kci_pkg::ST_IDLE) ? '0 : AW'(ptr_q);

	kci_ram #(.WIDTH(EW), .DEPTH(MAX_POINTS)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (AW'(cmd.point_index)),
		.wdata ({cmd.point_smooth, cmd.point_value, TIME_BITS'(cmd.point_time_ms)}),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	kci_div #(.DW(DW), .QW(17)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (div_go_q),
		.num    (div_num_q),
		.den    (div_den_q),
		.done   (div_done),
		.quot   (div_quot)
	);

	assign cur_t  = ram_rdata[TIME_BITS-1:0];
	assign cur_v  = ram_rdata[TIME_BITS+13:TIME_BITS];
	assign cur_sm = ram_rdata[EW-1];

	assign count_ext = NW'(count_q);
	assign cnt_eff   = (32'(count_ext) > MAX_POINTS) ? NW'(MAX_POINTS) : count_ext;

	assign hit     = have_prev_q && e_q >= CW'(prev_t_q) && e_q <= CW'(cur_t);
	assign seg_len = cur_t - prev_t_q;
	assign seg_off = TIME_BITS'(e_q - CW'(prev_t_q));

	assign poly = 51'({sq_q, 16'b0}) + 51'({sq_q, 17'b0}) - 51'({cu_q, 1'b0});
	assign dv   = $signed({1'b0, v1_q}) - $signed({1'b0, v0_q});
	assign sx   = $signed({1'b0, s_q});
	assign vsum = $signed({3'b0, v0_q, 16'b0}) + prod_q;
	assign xr   = 47'(x_q) + 47'(kci_pkg::ROUND_ADD);
	assign range_eff = (range_q == '0) ? 16'd1 : range_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			range_q <= 16'd1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				kci_pkg::REG_POINT_COUNT:  count_q <= cfg_data[5:0];
				kci_pkg::REG_OUTPUT_RANGE: range_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= kci_pkg::ST_IDLE;
			done_q   <= 1'b0;
			div_go_q <= 1'b0;
		end else begin
			done_q   <= 1'b0;
			div_go_q <= 1'b0;
			unique case (state_q)
				kci_pkg::ST_IDLE: begin
					if (accept && cmd.func == kci_pkg::FUNC_EVAL) begin
						if (cnt_eff == '0) begin
							done_q <= 1'b1;
						end else begin
							state_q <= kci_pkg::ST_SCAN;
						end
					end
				end
				kci_pkg::ST_SCAN: begin
					if (hit) begin
						if (seg_len == '0) begin
							state_q <= kci_pkg::ST_BLEND;
						end else begin
							div_go_q <= 1'b1;
							state_q  <= kci_pkg::ST_TDIV;
						end
					end else if (ptr_q == cnt_q) begin
						state_q <= kci_pkg::ST_SCALE;
					end
				end
				kci_pkg::ST_TDIV: begin
					if (div_done) begin
						state_q <= smooth_q ? kci_pkg::ST_SQ : kci_pkg::ST_BLEND;
					end
				end
				kci_pkg::ST_SQ:    state_q <= kci_pkg::ST_CU;
				kci_pkg::ST_CU:    state_q <= kci_pkg::ST_POLY;
				kci_pkg::ST_POLY:  state_q <= kci_pkg::ST_BLEND;
				kci_pkg::ST_BLEND: state_q <= kci_pkg::ST_SUM;
				kci_pkg::ST_SUM:   state_q <= kci_pkg::ST_SCALE;
				kci_pkg::ST_SCALE: state_q <= kci_pkg::ST_RND;
				kci_pkg::ST_RND:   state_q <= kci_pkg::ST_OCHK;
				kci_pkg::ST_OCHK: begin
					if (y_q >= 31'(kci_pkg::SAT_LIMIT)) begin
						done_q  <= 1'b1;
						state_q <= kci_pkg::ST_IDLE;
					end else begin
						state_q <= kci_pkg::ST_ODIV;
					end
				end
				kci_pkg::ST_ODIV: begin
					done_q  <= 1'b1;
					state_q <= kci_pkg::ST_IDLE;
				end
				default: state_q <= kci_pkg::ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			kci_pkg::ST_IDLE: begin
				e_q         <= CW'(cmd.eval_time_ms);
				cnt_q       <= cnt_eff;
				ptr_q       <= NW'(1);
				have_prev_q <= 1'b0;
				result_q    <= '{out_value: '0, in_segment: 1'b0, table_empty: 1'b1};
			end
			kci_pkg::ST_SCAN: begin
				prev_t_q    <= cur_t;
				prev_v_q    <= cur_v;
				prev_sm_q   <= cur_sm;
				have_prev_q <= 1'b1;
				ptr_q       <= ptr_q + 1'b1;
				v0_q        <= prev_v_q;
				v1_q        <= cur_v;
				smooth_q    <= prev_sm_q || cur_sm;
				seg_q       <= hit;
				s_q         <= '0;
				div_num_q   <= DW'({seg_off, 16'b0});
				div_den_q   <= DW'(seg_len);
				v_q         <= {cur_v, 16'b0};
			end
			kci_pkg::ST_TDIV: begin
				t_q <= div_quot;
				s_q <= div_quot;
			end
			kci_pkg::ST_SQ:    sq_q <= 34'(t_q) * 34'(t_q);
			kci_pkg::ST_CU:    cu_q <= 50'(sq_q) * 50'(t_q);
			kci_pkg::ST_POLY:  s_q <= poly[48:32];
			kci_pkg::ST_BLEND: prod_q <= dv * sx;
			kci_pkg::ST_SUM:   v_q <= vsum[32] ? '0 : vsum[29:0];
			kci_pkg::ST_SCALE: x_q <= 46'(v_q) * 46'(range_eff);
			kci_pkg::ST_RND:   y_q <= xr[46:16];
			kci_pkg::ST_OCHK: begin
				// divide by full scale through the reciprocal
				quo_q    <= 61'(y_q) * 61'(kci_pkg::RECIP_FULL_SCALE);
				result_q <= '{out_value: kci_pkg::OUT_MAX, in_segment: seg_q,
					table_empty: 1'b0};
			end
			kci_pkg::ST_ODIV: begin
				result_q <= '{out_value: quo_q[kci_pkg::RECIP_SHIFT +: 16],
					in_segment: seg_q, table_empty: 1'b0};
			end
			default: ;
		endcase
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

[rtl/kci_checker.sv]
module kci_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               start,
	input logic               busy,
	input kci_pkg::in_word_t  cmd,
	input logic               done,
	input kci_pkg::out_word_t result
);

	// an empty table never reports a segment
	a_empty_flags: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.table_empty |-> !result.in_segment && result.out_value == '0)
		else $error("empty table word carries data");

	// keyframe writes give no word
	a_write_silent: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && cmd.func == kci_pkg::FUNC_WRITE |=> !done)
		else $error("word after keyframe write");

	// work only begins with an accepted command
	a_busy_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start))
		else $error("busy without command");

	// the word is shown once the block is free again
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("word while busy");

endmodule

bind keyframe_curve_interpolator_top kci_checker u_kci_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.cmd    (cmd),
	.done   (done),
	.result (result)
);
